// ===== rtl/core/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants for the page table walker
// Entry layout, action codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

   localparam int VA_W    = 48;
   localparam int PA_W    = 52;
   localparam int ENTRY_W = 64;
   localparam int IDX_W   = 9;
   localparam int OFF_W   = 12;
   localparam int SADDR_W = 12;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 64;

   // action / result kind codes
   localparam logic [1:0] ACT_WRITE     = 2'd0;
   localparam logic [1:0] ACT_TRANSLATE = 2'd1;
   localparam logic [1:0] ACT_CHECK     = 2'd2;

   // register indexes, decoded from paddr[3]
   localparam logic REG_ROOT   = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   // entry bits
   localparam int PRESENT_BIT = 0;
   localparam int HUGE_BIT    = 7;

   localparam logic [PA_W-1:0] FRAME_MASK = 52'hF_FFFF_FFFF_F000;

   // walk levels
   localparam logic [1:0] LVL_TOP  = 2'd0;
   localparam logic [1:0] LVL_DIR  = 2'd1;
   localparam logic [1:0] LVL_MID  = 2'd2;
   localparam logic [1:0] LVL_LAST = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_DONE = 4'b1000
   } ptw_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/ptw_addr_unit.sv =====
// ----------------------------------------------------------------------------
// ptw_addr_unit: entry word address unit
// word = ((window + (base & frame mask)) >> 3) + index, mod store depth.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_addr_unit #(
   parameter int ADDR_W = 12
) (
   input  logic [ptw_pkg::PA_W-1:0]  window,
   input  logic [ptw_pkg::PA_W-1:0]  base,
   input  logic [ptw_pkg::IDX_W-1:0] index,
   output logic [ADDR_W-1:0]         word_addr
);
   import ptw_pkg::*;

   // only the bits below the store depth survive the modulo
   logic [PA_W-1:0]   frame;
   logic [ADDR_W+2:0] byte_sum;

   assign frame     = base & FRAME_MASK;
   assign byte_sum  = window[ADDR_W+2:0] + frame[ADDR_W+2:0];
   assign word_addr = byte_sum[ADDR_W+2:3] + ADDR_W'(index);

endmodule

`default_nettype wire

// ===== rtl/core/ptw_table_store.sv =====
// ----------------------------------------------------------------------------
// ptw_table_store: page table word memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_table_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [ptw_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [ptw_pkg::ENTRY_W-1:0] rd_data
);
   import ptw_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/four_level_page_table_walker_core.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core: four-level page table walker
// Table store plus a walk sequencer that reuses one address unit per level.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------------
//   req     | in        | req_valid / req_stall  | action, VA, store addr, data
//   rsp     | out       | rsp_valid / rsp_stall  | kind, success, phys address
//   csr     | in/out    | psel/penable, pready=1 | root base @0x0, window @0x8
//
// A store write or an unknown action goes from accept to ST_DONE and then to
// the result register. A walk passes ST_READ and ST_EVAL per level read;
// each level is one store read (registered read data on the single read port)
// followed by one evaluate state, and the next address depends on that entry.
// req_stall is high from accept until the result moves into the output
// register; a new word is taken while a result still waits on rsp_stall.
// Reset (synchronous) clears control state and both registers; the store
// itself is not cleared. STORE_DEPTH must be a power of two.
//
`default_nettype none

module four_level_page_table_walker_core #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic [ptw_pkg::VA_W-1:0]    req_virtual_address,
   input  logic [ptw_pkg::SADDR_W-1:0] req_store_address,
   input  logic [ptw_pkg::ENTRY_W-1:0] req_store_data,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_result_kind,
   output logic                        rsp_success,
   output logic [ptw_pkg::PA_W-1:0]    rsp_phys_addr,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ptw_pkg::CSR_AW-1:0]  paddr,
   input  logic [ptw_pkg::CSR_DW-1:0]  pwdata,
   output logic [ptw_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import ptw_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // sequencer state
   ptw_state_type     state_ff, state_in;
   logic [1:0]        level_ff, level_in;
   logic [1:0]        action_ff, action_in;
   logic [VA_W-1:0]   va_ff, va_in;
   logic [PA_W-1:0]   base_ff, base_in;
   logic              ok_ff, ok_in;
   logic [PA_W-1:0]   pa_ff, pa_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [PA_W-1:0]   rsp_pa_ff, rsp_pa_in;

   // configuration registers
   logic [PA_W-1:0]   root_ff, root_in;
   logic [PA_W-1:0]   window_ff, window_in;

   logic              req_accept;
   logic              rsp_accept;
   logic              rsp_load;
   logic              csr_write;
   logic              is_translate;
   logic              entry_present;
   logic              entry_huge;
   logic [IDX_W-1:0]  index_sel;
   logic [ADDR_W-1:0] word_addr;
   logic [ADDR_W+SADDR_W-1:0] wr_addr_ext;
   logic [ENTRY_W-1:0] entry;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_write  = psel && penable && pwrite && pready;
   assign pready     = 1'b1;

   // ---------------------------------------------------------------- csr
   always_comb begin
      root_in   = root_ff;
      window_in = window_ff;
      if (csr_write) begin
         case (paddr[3])
            REG_ROOT:   root_in   = pwdata[PA_W-1:0];
            REG_WINDOW: window_in = pwdata[PA_W-1:0];
            default:    root_in   = root_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3])
         REG_ROOT:   prdata = {{(CSR_DW-PA_W){1'b0}}, root_ff};
         REG_WINDOW: prdata = {{(CSR_DW-PA_W){1'b0}}, window_ff};
         default:    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- store
   // store_address wraps modulo the depth
   assign wr_addr_ext = {{ADDR_W{1'b0}}, req_store_address};

   ptw_table_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept && (req_action == ACT_WRITE)),
      .wr_addr (wr_addr_ext[ADDR_W-1:0]),
      .wr_data (req_store_data),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (word_addr),
      .rd_data (entry)
   );

   // ---------------------------------------------------------------- address
   // 9-bit table index for the current level
   always_comb begin
      case (level_ff)
         LVL_TOP:  index_sel = va_ff[47:39];
         LVL_DIR:  index_sel = va_ff[38:30];
         LVL_MID:  index_sel = va_ff[29:21];
         LVL_LAST: index_sel = va_ff[20:12];
         default:  index_sel = '0;
      endcase
   end

   ptw_addr_unit #(
      .ADDR_W (ADDR_W)
   ) u_addr (
      .window    (window_ff),
      .base      (base_ff),
      .index     (index_sel),
      .word_addr (word_addr)
   );

   // ---------------------------------------------------------------- walk
   assign is_translate  = (action_ff == ACT_TRANSLATE);
   assign entry_present = entry[PRESENT_BIT];
   assign entry_huge    = entry[HUGE_BIT];

   always_comb begin
      state_in  = state_ff;
      level_in  = level_ff;
      action_in = action_ff;
      va_in     = va_ff;
      base_in   = base_ff;
      ok_in     = ok_ff;
      pa_in     = pa_ff;
      rsp_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_action;
               va_in     = req_virtual_address;
               base_in   = root_ff;
               level_in  = LVL_TOP;
               ok_in     = 1'b0;
               pa_in     = '0;
               if (req_action == ACT_TRANSLATE || req_action == ACT_CHECK) begin
                  state_in = ST_READ;
               end else begin
                  // write ack succeeds, unknown action reports failure
                  ok_in    = (req_action == ACT_WRITE);
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!entry_present) begin
               ok_in    = 1'b0;
               state_in = ST_DONE;
            end else if ((level_ff == LVL_DIR || level_ff == LVL_MID) && entry_huge) begin
               // huge page: mapped, but not translatable
               ok_in    = !is_translate;
               state_in = ST_DONE;
            end else if (level_ff == LVL_LAST) begin
               ok_in    = 1'b1;
               pa_in    = is_translate ? {entry[PA_W-1:OFF_W], va_ff[OFF_W-1:0]} : '0;
               state_in = ST_DONE;
            end else begin
               base_in  = entry[PA_W-1:0];
               level_in = level_ff + 2'd1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pa_in    = rsp_pa_ff;
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = action_ff;
         rsp_ok_in    = ok_ff;
         rsp_pa_in    = pa_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_success     = rsp_ok_ff;
   assign rsp_phys_addr   = rsp_pa_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= LVL_TOP;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
         window_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         root_ff      <= root_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      va_ff       <= va_in;
      base_ff     <= base_in;
      ok_ff       <= ok_in;
      pa_ff       <= pa_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_pa_ff   <= rsp_pa_in;
   end

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("walker state not one-hot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");

   a_last_level_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && level_ff == LVL_LAST) |=> (state_ff == ST_DONE))
      else $error("walk ran past the last level");

   a_pa_only_on_translate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pa_ff == '0 || (rsp_kind_ff == ACT_TRANSLATE && rsp_ok_ff)))
      else $error("physical address on a non-translate result");
`endif

endmodule

`default_nettype wire
